>>> rtl/usvt_pkg.sv
// ----------------------------------------------------------------------------
// usvt_pkg: shared types and constants for the unique value set table
// Table capacity, derived widths, command and status codes, result record.
// ----------------------------------------------------------------------------
package usvt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;
    localparam int POS_W    = 7;
    localparam int ICNT_W   = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd4;
    localparam logic [STAT_W-1:0] ST_FOUND   = 3'd5;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [ICNT_W-1:0] item_count;
        logic              is_empty;
    } t_result;

endpackage

>>> rtl/usvt_engine.sv
// ----------------------------------------------------------------------------
// usvt_engine: table memory and search / compaction sequencer
// Walks the table one entry at a time through a single read port and
// one compare unit; removal shifts later entries down one place at a time.
// ----------------------------------------------------------------------------
module usvt_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [usvt_pkg::CMD_W-1:0]   i_cmd,
    input  logic [usvt_pkg::VAL_W-1:0]   i_val,
    output logic                         o_busy,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output usvt_pkg::t_result            o_res
);
    import usvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MISS,
        S_SHRD,
        S_SHWR,
        S_RES
    } t_state;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [IDX_W-1:0]    r_pos, n_pos;

    logic [VAL_W-1:0]    mem [CAPACITY];
    logic [VAL_W-1:0]    r_rd_data;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [VAL_W-1:0]    wr_data;
    logic [CNT_W-1:0]    idx_next;

    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_pos    = r_pos;
        rd_addr  = r_idx;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_val   = i_val;
                    n_idx   = '0;
                    n_state = (r_count == '0) ? S_MISS : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_data == r_val) begin
                    n_pos = r_idx;
                    if (r_cmd == CMD_INSERT) begin
                        n_status = ST_PRESENT;
                        n_state  = S_RES;
                    end else if (r_cmd == CMD_REMOVE) begin
                        n_state = S_SHRD;
                    end else begin
                        n_status = ST_FOUND;
                        n_state  = S_RES;
                    end
                end else if (idx_next == r_count) begin
                    n_state = S_MISS;
                end else begin
                    n_idx   = IDX_W'(idx_next);
                    n_state = S_RD;
                end
            end
            S_MISS: begin
                n_pos = '0;
                if (r_cmd == CMD_INSERT) begin
                    if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = IDX_W'(r_count);
                        wr_data  = r_val;
                        n_pos    = IDX_W'(r_count);
                        n_count  = r_count + CNT_W'(1);
                        n_status = ST_ADDED;
                    end
                end else begin
                    n_status = ST_ABSENT;
                end
                n_state = S_RES;
            end
            S_SHRD: begin
                // fetch the entry above the gap, or close out the removal
                rd_addr = IDX_W'(idx_next);
                if (idx_next < r_count) begin
                    n_state = S_SHWR;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_REMOVED;
                    n_state  = S_RES;
                end
            end
            S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rd_data;
                n_idx   = IDX_W'(idx_next);
                n_state = S_SHRD;
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ST_ABSENT;
            r_pos    <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            r_pos    <= n_pos;
            r_idx    <= n_idx;
        end
        r_cmd <= n_cmd;
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_res_valid         = (r_state == S_RES);
    assign o_res.status        = r_status;
    assign o_res.position      = POS_W'(r_pos);
    assign o_res.item_count    = ICNT_W'(r_count);
    assign o_res.is_empty      = (r_count == '0);

endmodule

>>> rtl/unique_value_set_table.sv
// ----------------------------------------------------------------------------
// unique_value_set_table: set of distinct 32-bit values in insertion order
// Insert, remove and look up values in a packed table of fixed capacity.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid with i_command / i_value; the block raises
//   o_in_stall while it works on an item. command insert, remove, look up
//   (code 3 behaves as look up).
//   output channel: one item per input item on o_out_valid with o_status,
//   o_position, o_item_count, o_is_empty; i_out_stall holds it in place.
//   operation: the table is scanned through one read port and one comparator,
//   one entry examined at a time; a removal then moves each later entry
//   down one place at a time. the block works on one item at a time: the
//   next item is taken only once the result of the last has left the engine.
//   a finished item sits in the output register, so the next input item is
//   taken while it waits; with both the engine result and the output
//   register held, the engine waits and o_in_stall stays high.
//   reset: synchronous, active low; the table comes up empty, no clearing
//   pass is needed since only entries below the count are used.
// ----------------------------------------------------------------------------
module unique_value_set_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [usvt_pkg::CMD_W-1:0]    i_command,
    input  logic signed [usvt_pkg::VAL_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [usvt_pkg::STAT_W-1:0]   o_status,
    output logic [usvt_pkg::POS_W-1:0]    o_position,
    output logic [usvt_pkg::ICNT_W-1:0]   o_item_count,
    output logic                          o_is_empty
);
    import usvt_pkg::*;

    logic     busy;
    logic     start;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    t_result  r_out;
    logic     r_out_valid;

    assign start     = i_in_valid && !busy;
    assign res_ready = !r_out_valid || !i_out_stall;

    usvt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_command),
        .i_val       (VAL_W'(i_value)),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register parts the engine from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_position   = r_out.position;
    assign o_item_count = r_out.item_count;
    assign o_is_empty   = r_out.is_empty;

endmodule

>>> tb/tb_unique_value_set_table.sv
// ----------------------------------------------------------------------------
// tb_unique_value_set_table: self-checking bench for the unique value set table
// Drives insert, remove and look-up items through the stall handshake, keeps
// its own table of held values to predict each reply, and checks every reply
// field against the oldest prediction under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_unique_value_set_table;
    timeunit 1ns;
    timeprecision 1ps;

    import usvt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, behaves as look-up
    localparam int POOL_N      = 192;
    localparam int DRAIN_WAIT  = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_SEG       = 7;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VAL_W-1:0] value;
    } t_cmd_item;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command = '0;
    logic signed [VAL_W-1:0]  i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [STAT_W-1:0]        o_status;
    logic [POS_W-1:0]         o_position;
    logic [ICNT_W-1:0]        o_item_count;
    logic                     o_is_empty;

    t_cmd_item   cmds_to_send[$];
    t_result     replies_due[$];
    logic [31:0] held_vals[CAPACITY];
    int          held_cnt = 0;
    logic [31:0] value_pool[POOL_N];
    int          pool_ptr = 0;
    int          send_idle_pct = 22;
    int          recv_idle_pct = 61;
    int          n_mismatch = 0;
    int          cycle_cnt = 0;

    // per random segment: insert and remove percentages, item count
    int seg_ins[N_SEG] = '{92, 45, 5, 70, 40, 85, 10};
    int seg_rem[N_SEG] = '{4, 40, 90, 20, 45, 10, 85};
    int seg_len[N_SEG] = '{250, 200, 200, 200, 200, 200, 200};

    unique_value_set_table uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_item_count (o_item_count),
        .o_is_empty   (o_is_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // applies one command to the held table and returns the reply it causes
    function automatic t_result apply_set_cmd(logic [CMD_W-1:0] cmd, logic [31:0] val);
        t_result r;
        int      hit_at;
        int      i;
        hit_at = -1;
        for (i = 0; i < held_cnt; i++) begin
            if (hit_at < 0 && held_vals[i] == val)
                hit_at = i;
        end
        r.position = '0;
        if (cmd == CMD_INSERT) begin
            // duplicate check wins over the full check
            if (hit_at >= 0) begin
                r.status   = ST_PRESENT;
                r.position = hit_at[POS_W-1:0];
            end else if (held_cnt >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                r.status = ST_ADDED;
                r.position = held_cnt[POS_W-1:0];
                held_vals[held_cnt] = val;
                held_cnt++;
            end
        end else if (cmd == CMD_REMOVE) begin
            if (hit_at >= 0) begin
                r.status   = ST_REMOVED;
                r.position = hit_at[POS_W-1:0];
                for (i = hit_at; i + 1 < held_cnt; i++)
                    held_vals[i] = held_vals[i + 1];
                held_cnt--;
            end else begin
                r.status = ST_ABSENT;
            end
        end else begin
            if (hit_at >= 0) begin
                r.status   = ST_FOUND;
                r.position = hit_at[POS_W-1:0];
            end else begin
                r.status = ST_ABSENT;
            end
        end
        r.item_count = held_cnt[ICNT_W-1:0];
        r.is_empty   = (held_cnt == 0);
        return r;
    endfunction

    // driver: predicts on acceptance, then loads the next item or idles
    always @(posedge i_clk) begin : drive_proc
        t_cmd_item nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                replies_due.push_back(apply_set_cmd(i_command, i_value));
            if (!i_in_valid || !o_in_stall) begin
                if (cmds_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmds_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_command  <= nxt.command;
                    i_value    <= nxt.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted reply against the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_position, o_item_count, o_is_empty};
            if (replies_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected reply: status %0d pos %0d count %0d empty %0b",
                             got.status, got.position, got.item_count, got.is_empty);
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("reply mismatch: expected status %0d pos %0d count %0d empty %0b",
                                 want.status, want.position, want.item_count, want.is_empty);
                        $display("                got      status %0d pos %0d count %0d empty %0b",
                                 got.status, got.position, got.item_count, got.is_empty);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_unique_value_set_table: FAIL");
            $finish;
        end
    end

    task automatic post_cmd(logic [CMD_W-1:0] cmd, logic [31:0] val);
        while (cmds_to_send.size() >= 2)
            @(negedge i_clk);
        cmds_to_send.push_back('{command: cmd, value: val});
    endtask

    // inserts mostly walk the pool for fresh values; removes and look-ups
    // mostly aim at values currently held so the table churns and drains
    task automatic post_random(int ins_pct, int rem_pct);
        int               roll;
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [31:0]      val;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            cmd = CMD_INSERT;
        else if (roll < ins_pct + rem_pct)
            cmd = CMD_REMOVE;
        else if (roll < 97)
            cmd = CMD_LOOKUP;
        else
            cmd = CMD_SPARE;
        if (cmd == CMD_INSERT) begin
            if ($urandom_range(9) < 7) begin
                val = value_pool[pool_ptr];
                pool_ptr = (pool_ptr + 1) % POOL_N;
            end else begin
                val = value_pool[$urandom_range(POOL_N - 1)];
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 85 && held_cnt > 0)
                val = held_vals[$urandom_range(held_cnt - 1)];
            else if (pick < 93)
                val = value_pool[$urandom_range(POOL_N - 1)];
            else
                val = $urandom;
        end
        post_cmd(cmd, val);
    endtask

    task automatic wait_drained();
        while (cmds_to_send.size() != 0 || i_in_valid || replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin : stim_proc
        int s;
        int k;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < POOL_N; k++)
            value_pool[k] = $urandom;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, duplicate, spare code, shifts
        post_cmd(CMD_LOOKUP, 32'h0000_0005);
        post_cmd(CMD_REMOVE, 32'h0000_0005);
        post_cmd(CMD_INSERT, 32'h8000_0000);
        post_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        post_cmd(CMD_INSERT, 32'h0000_0000);
        post_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        post_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        post_cmd(CMD_LOOKUP, 32'h8000_0000);
        post_cmd(CMD_SPARE,  32'hFFFF_FFFF);
        post_cmd(CMD_SPARE,  32'h1234_5678);
        post_cmd(CMD_REMOVE, 32'h0000_0000);
        post_cmd(CMD_LOOKUP, 32'hFFFF_FFFF);
        post_cmd(CMD_REMOVE, 32'h5555_5555);
        post_cmd(CMD_INSERT, 32'hAAAA_AAAA);
        post_cmd(CMD_INSERT, 32'h5555_5555);
        post_cmd(CMD_REMOVE, 32'h8000_0000);
        post_cmd(CMD_LOOKUP, 32'h5555_5555);
        post_cmd(CMD_REMOVE, 32'h5555_5555);
        post_cmd(CMD_REMOVE, 32'h7FFF_FFFF);
        post_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
        post_cmd(CMD_REMOVE, 32'hAAAA_AAAA);
        post_cmd(CMD_LOOKUP, 32'hAAAA_AAAA);
        wait_drained();

        // random: fill to full (full and duplicate-when-full cases), churn, drain
        for (s = 0; s < N_SEG; s++) begin
            if (s == 3) begin
                send_idle_pct = 61;
                recv_idle_pct = 22;
            end else if (s == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (k = 0; k < seg_len[s]; k++)
                post_random(seg_ins[s], seg_rem[s]);
            // hold off until every reply is back
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (n_mismatch == 0 && replies_due.size() == 0)
            $display("tb_unique_value_set_table: PASS");
        else
            $display("tb_unique_value_set_table: FAIL");
        $finish;
    end

endmodule
